>>> rtl/fcpc_pkg.sv
// Shared types and constants for the face crossfade pixel compositor.
`timescale 1ns / 1ps

package fcpc_pkg;

	localparam int unsigned LANES = 3;

	localparam logic [8:0]  Q_ONE        = 9'd256;
	localparam logic [7:0]  WHITE_LEVEL  = 8'd230;
	localparam logic [7:0]  DRAW_LEVEL   = 8'd12;
	localparam logic [16:0] MIX_ROUND    = 17'd128;
	localparam logic [9:0]  DIV3_MUL     = 10'd683;
	localparam logic [16:0] BASE_ROUND   = 17'd128;
	localparam logic [24:0] BLEND_ROUND  = 25'd32640;
	localparam logic [16:0] BLEND_SAT    = 17'd65280;
	localparam logic [7:0]  CHAN_MAX     = 8'd255;

	typedef enum logic [0:0] {
		CFG_FACE_OPACITY = 1'b0,
		CFG_SMILE_AMOUNT = 1'b1
	} fcpc_cfg_idx_t;

	typedef struct packed {
		logic [7:0] rain_level;
		logic       over_face;
		logic [7:0] neutral_red;
		logic [7:0] neutral_green;
		logic [7:0] neutral_blue;
		logic [7:0] half_red;
		logic [7:0] half_green;
		logic [7:0] half_blue;
		logic [7:0] full_red;
		logic [7:0] full_green;
		logic [7:0] full_blue;
	} fcpc_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       draw_glyph;
	} fcpc_out_t;

	// Per-transaction control that travels beside the lane data.
	typedef struct packed {
		logic       valid;
		logic       face_on;
		logic       white;
		logic [7:0] level;
	} fcpc_ctl_t;

endpackage

>>> rtl/fcpc_mix_lane.sv
// One color lane of the frame crossfade: selects the frame pair and mixes it.
`timescale 1ns / 1ps

module fcpc_mix_lane (
	input  logic       clk,
	input  logic [7:0] f0,
	input  logic [7:0] f1,
	input  logic [7:0] f2,
	input  logic       pair_hi,
	input  logic [8:0] t,
	output logic [7:0] m_s1
);
	import fcpc_pkg::*;

	logic [7:0]  lo_px;
	logic [7:0]  hi_px;
	logic [8:0]  w_lo;
	logic [16:0] acc;

	assign lo_px = pair_hi ? f1 : f0;
	assign hi_px = pair_hi ? f2 : f1;
	assign w_lo  = Q_ONE - t;
	assign acc   = 17'(lo_px) * 17'(w_lo) + 17'(hi_px) * 17'(t) + MIX_ROUND;

	always_ff @(posedge clk) begin
		m_s1 <= acc[15:8];
	end

endmodule

>>> rtl/fcpc_merge.sv
// Merge stage: luminance of the mixed lanes and the raised cell intensity.
`timescale 1ns / 1ps

module fcpc_merge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [2:0][7:0]        m_s1,
	input  fcpc_pkg::fcpc_ctl_t    ctl_s1,
	input  logic [8:0]             opacity,
	output logic [2:0][7:0]        m_s3,
	output fcpc_pkg::fcpc_ctl_t    ctl_s3,
	output logic [7:0]             lvl_up_s3
);
	import fcpc_pkg::*;

	logic [9:0]      sum;
	logic [19:0]     lum_prod;
	logic [7:0]      lum_s2;
	logic [2:0][7:0] m_s2;
	fcpc_ctl_t       ctl_s2;
	logic [16:0]     base_acc;
	logic [7:0]      base;

	// Floor of sum/3 as a reciprocal multiply; exact for sums below 2048.
	assign sum      = 10'(m_s1[0]) + 10'(m_s1[1]) + 10'(m_s1[2]);
	assign lum_prod = 20'(sum) * 20'(DIV3_MUL);

	assign base_acc = 17'(opacity) * 17'(lum_s2) + BASE_ROUND;
	assign base     = base_acc[15:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		lum_s2 <= lum_prod[18:11];
		m_s2   <= m_s1;
		m_s3   <= m_s2;
		// Raise intensity to the face baseline only where the face applies.
		if (ctl_s2.face_on && (base > ctl_s2.level))
			lvl_up_s3 <= base;
		else
			lvl_up_s3 <= ctl_s2.level;
	end

endmodule

>>> rtl/fcpc_blend_lane.sv
// One color lane of the rain/image alpha blend with rounding and saturation.
`timescale 1ns / 1ps

module fcpc_blend_lane (
	input  logic       clk,
	input  logic       face_on_s3,
	input  logic [7:0] rain_c_s3,
	input  logic [7:0] m_s3,
	input  logic [7:0] lvl_up_s3,
	input  logic [8:0] opacity,
	output logic [7:0] chan_s6
);
	import fcpc_pkg::*;

	logic [16:0] p_s4;
	logic [15:0] q_s4;
	logic [7:0]  rc_s4;
	logic        face_s4;
	logic [24:0] num_s5;
	logic [7:0]  rc_s5;
	logic        face_s5;
	logic [8:0]  w_rain;
	logic [24:0] rounded;
	logic [16:0] y;
	logic [16:0] d;
	logic [7:0]  v;

	assign w_rain = Q_ONE - opacity;

	// Divide by 65280 as >>8 then /255; /255 via add of the high byte.
	assign rounded = num_s5 + BLEND_ROUND;
	assign y       = rounded[24:8];
	assign d       = 17'(y[15:0]) + 17'd1 + 17'(y[15:8]);
	assign v       = (y >= BLEND_SAT) ? CHAN_MAX : d[15:8];

	always_ff @(posedge clk) begin
		p_s4    <= 17'(rain_c_s3) * 17'(w_rain);
		q_s4    <= 16'(m_s3) * 16'(lvl_up_s3);
		rc_s4   <= rain_c_s3;
		face_s4 <= face_on_s3;

		num_s5  <= (25'(p_s4) << 8) - 25'(p_s4) + 25'(q_s4) * 25'(opacity);
		rc_s5   <= rc_s4;
		face_s5 <= face_s4;

		chan_s6 <= face_s5 ? v : rc_s5;
	end

endmodule

>>> rtl/face_crossfade_pixel_compositor_top.sv
// Top level of the face crossfade pixel compositor: config, lanes and merge.
// A transaction accepted on start passes through stages s1 to s6 and then shows on result with done.
// Throughput: one transaction per cycle; busy stays low, three color lanes run in parallel.
// The six-stage pipeline is set by the mix, luminance, baseline and blend multipliers.
// Results cannot be stalled: done is a single-cycle strobe.
// Reset clears face_opacity, smile_amount and all in-flight transactions.
`timescale 1ns / 1ps

module face_crossfade_pixel_compositor_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  fcpc_pkg::fcpc_in_t      item,
	output logic                    done,
	output fcpc_pkg::fcpc_out_t     result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  fcpc_pkg::fcpc_cfg_idx_t cfg_index,
	input  logic [8:0]              cfg_data
);
	import fcpc_pkg::*;

	logic [8:0]      opacity_q;
	logic [8:0]      smile_q;
	logic [8:0]      cfg_sat;
	logic            pair_hi;
	logic [8:0]      t;
	logic [2:0][7:0] f0;
	logic [2:0][7:0] f1;
	logic [2:0][7:0] f2;
	logic [2:0][7:0] m_s1;
	logic [2:0][7:0] m_s3;
	logic [2:0][7:0] rain_c_s3;
	logic [2:0][7:0] chan_s6;
	fcpc_ctl_t       ctl_s1;
	fcpc_ctl_t       ctl_s3;
	logic [7:0]      lvl_up_s3;
	logic            valid_s4;
	logic            valid_s5;
	logic            valid_s6;
	logic            draw_s4;
	logic            draw_s5;
	logic            draw_s6;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_sat   = (cfg_data > Q_ONE) ? Q_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= '0;
			smile_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FACE_OPACITY: opacity_q <= cfg_sat;
				CFG_SMILE_AMOUNT: smile_q   <= cfg_sat;
				default:          ;
			endcase
		end
	end

	// Upper half of the smile range blends frames 1/2 with weight 2*(s-128).
	assign pair_hi = smile_q[8] | smile_q[7];
	assign t       = {smile_q[8], smile_q[6:0], 1'b0};

	assign f0 = {item.neutral_blue, item.neutral_green, item.neutral_red};
	assign f1 = {item.half_blue, item.half_green, item.half_red};
	assign f2 = {item.full_blue, item.full_green, item.full_red};

	for (genvar k = 0; k < LANES; k++) begin : g_mix
		fcpc_mix_lane u_mix (
			.clk     (clk),
			.f0      (f0[k]),
			.f1      (f1[k]),
			.f2      (f2[k]),
			.pair_hi (pair_hi),
			.t       (t),
			.m_s1    (m_s1[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			ctl_s1.valid   <= start && !busy;
			ctl_s1.face_on <= item.over_face && (opacity_q != '0);
			ctl_s1.white   <= item.rain_level >= WHITE_LEVEL;
			ctl_s1.level   <= item.rain_level;
			valid_s4       <= ctl_s3.valid;
			valid_s5       <= valid_s4;
			valid_s6       <= valid_s5;
		end
	end

	fcpc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.m_s1      (m_s1),
		.ctl_s1    (ctl_s1),
		.opacity   (opacity_q),
		.m_s3      (m_s3),
		.ctl_s3    (ctl_s3),
		.lvl_up_s3 (lvl_up_s3)
	);

	// Rain color: green, or white at high intensity.
	assign rain_c_s3[0] = ctl_s3.white ? ctl_s3.level : 8'd0;
	assign rain_c_s3[1] = ctl_s3.level;
	assign rain_c_s3[2] = ctl_s3.white ? ctl_s3.level : 8'd0;

	for (genvar k = 0; k < LANES; k++) begin : g_blend
		fcpc_blend_lane u_blend (
			.clk        (clk),
			.face_on_s3 (ctl_s3.face_on),
			.rain_c_s3  (rain_c_s3[k]),
			.m_s3       (m_s3[k]),
			.lvl_up_s3  (lvl_up_s3),
			.opacity    (opacity_q),
			.chan_s6    (chan_s6[k])
		);
	end

	always_ff @(posedge clk) begin
		draw_s4 <= lvl_up_s3 > DRAW_LEVEL;
		draw_s5 <= draw_s4;
		draw_s6 <= draw_s5;
	end

	assign done              = valid_s6;
	assign result.out_red    = chan_s6[0];
	assign result.out_green  = chan_s6[1];
	assign result.out_blue   = chan_s6[2];
	assign result.draw_glyph = draw_s6;

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##6 !done)
		else $error("result without an accepted transaction");

	a_rain_only: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !item.over_face && (item.rain_level < WHITE_LEVEL)) |-> ##6
		(result.out_red == 8'd0 && result.out_blue == 8'd0 &&
		 result.out_green == $past(item.rain_level, 6)))
		else $error("off-face cell did not pass the green rain color");

	a_rain_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !item.over_face) |-> ##6
		(result.draw_glyph == ($past(item.rain_level, 6) > DRAW_LEVEL)))
		else $error("off-face draw flag does not follow rain level");

endmodule
